// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define JDM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// property checked at every edge, reset included
`define JDM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== hdl/jdm_pkg.sv =====
// ----------------------------------------------------------------------------
// jdm_pkg
// shared types, codes, tables and arithmetic helpers of the stick mapper
// ----------------------------------------------------------------------------
`default_nettype none

package jdm_pkg;

    typedef struct packed {
        logic [10:0] stick_radius;
        logic [10:0] dead_radius;
        logic        pad_mode;
        logic [4:0]  sector_count;
        logic        button_mode;
    } t_cfg;

    localparam logic [2:0] CFG_STICK_RADIUS = 3'd0;
    localparam logic [2:0] CFG_DEAD_RADIUS  = 3'd1;
    localparam logic [2:0] CFG_PAD_MODE     = 3'd2;
    localparam logic [2:0] CFG_SECTOR_COUNT = 3'd3;
    localparam logic [2:0] CFG_BUTTON_MODE  = 3'd4;

    localparam logic [1:0] OP_BEGAN = 2'd0;
    localparam logic [1:0] OP_MOVED = 2'd1;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    // pipeline map
    localparam int ST_CMP     = 2;
    localparam int ST_VEC0    = 3;
    localparam int CORDIC_N   = 16;
    localparam int VDIV_STEPS = 15;
    localparam int ST_SNAP    = 19;
    localparam int ST_SDIV0   = 20;
    localparam int SDIV_STG   = 8;
    localparam int SDIV_PER   = 3;
    localparam int ST_ROTI    = 28;
    localparam int ST_ROT0    = 29;
    localparam int ST_FLIP    = 45;
    localparam int ST_MUL     = 46;
    localparam int ST_OUT     = 47;
    localparam int NUM_STAGES = 48;

    localparam int VD_W = 26;
    localparam int SD_W = 29;
    localparam int RX_W = 34;
    localparam int RZ_W = 18;

    localparam logic signed [RX_W-1:0] ROT_GAIN = 34'sd652032874;

    localparam logic [15:0] ATAN_UNITS [CORDIC_N] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
    };

    // one restoring step, 11-bit divisor
    function automatic logic [VD_W-1:0] vdiv_step(input logic [VD_W-1:0] w,
                                                 input logic [10:0] d);
        logic [11:0] t;
        logic [11:0] rem;
        logic        q;
        t = {w[25:15], w[14]};
        if (t >= {1'b0, d}) begin
            rem = t - {1'b0, d};
            q   = 1'b1;
        end else begin
            rem = t;
            q   = 1'b0;
        end
        return {rem[10:0], w[13:0], q};
    endfunction

    // one restoring step, 5-bit divisor
    function automatic logic [SD_W-1:0] sdiv_step(input logic [SD_W-1:0] w,
                                                 input logic [4:0] d);
        logic [5:0] t;
        logic [5:0] rem;
        logic       q;
        t = {w[28:24], w[23]};
        if (t >= {1'b0, d}) begin
            rem = t - {1'b0, d};
            q   = 1'b1;
        end else begin
            rem = t;
            q   = 1'b0;
        end
        return {rem[4:0], w[22:0], q};
    endfunction

    // q3.30 to q1.14, round half up, clamp
    function automatic logic signed [15:0] to_q14(input logic signed [RX_W-1:0] v);
        logic signed [RX_W-1:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) begin
            t = 34'sd16384;
        end else if (t < -34'sd16384) begin
            t = -34'sd16384;
        end
        return 16'(t);
    endfunction

    // quotient to signed velocity
    function automatic logic signed [15:0] div_vel(input logic [VD_W-1:0] w,
                                                  input logic neg);
        logic [15:0] q;
        q = {1'b0, w[14:0]};
        if (q > 16'd16384) begin
            q = 16'd16384;
        end
        return neg ? -q : q;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/jdm_datapath.sv =====
// ----------------------------------------------------------------------------
// jdm_datapath
// stage registers of the mapper: squares, cordic vectoring with velocity
// division alongside, sector snapping, cordic rotation, clamp and direction
// ----------------------------------------------------------------------------
`default_nettype none

module jdm_datapath #(
    parameter int COORD_BITS      = 12,
    parameter int NEAR_ZERO_LIMIT = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire jdm_pkg::t_cfg                 i_cfg,
    input  wire logic [1:0]                    i_operation,
    input  wire logic signed [COORD_BITS-1:0]  i_offset_x,
    input  wire logic signed [COORD_BITS-1:0]  i_offset_y,
    output logic                               o_kill,
    output logic signed [15:0]                 o_velocity_x,
    output logic signed [15:0]                 o_velocity_y,
    output logic [15:0]                        o_angle,
    output logic signed [COORD_BITS-1:0]       o_thumb_x,
    output logic signed [COORD_BITS-1:0]       o_thumb_y,
    output logic [2:0]                         o_direction,
    output logic                               o_in_dead_zone
);
    import jdm_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int WV = CB + 23;
    localparam int TW = ((CB > 12) ? CB : 12) + 1;
    localparam int DQ = ((2 * CB + 1) > 22) ? (2 * CB + 1) : 22;
    localparam int NW = CB + 15;

    typedef struct packed {
        logic                    began;
        logic                    dead;
        logic                    clamp;
        logic                    pad;
        logic signed [CB-1:0]    x;
        logic signed [CB-1:0]    y;
        logic [2*CB-1:0]         xx;
        logic [2*CB-1:0]         yy;
        logic signed [WV-1:0]    vx_c;
        logic signed [WV-1:0]    vy_c;
        logic [15:0]             z;
        logic [VD_W-1:0]         wx;
        logic [VD_W-1:0]         wy;
        logic [15:0]             ang;
        logic [4:0]              n;
        logic [SD_W-1:0]         sw;
        logic signed [RZ_W-1:0]  rz;
        logic signed [RX_W-1:0]  rx;
        logic signed [RX_W-1:0]  ry;
        logic                    flip;
        logic signed [15:0]      qx;
        logic signed [15:0]      qy;
        logic signed [TW-1:0]    tcx;
        logic signed [TW-1:0]    tcy;
        logic [2:0]              dir;
    } t_item;

    t_item       r_pl [NUM_STAGES];
    logic [21:0] r_rad_sq;
    logic [21:0] r_dead_sq;
    logic [21:0] w_rad_ext;
    logic [21:0] w_dead_ext;
    logic [DQ-1:0] w_dsq;

    assign w_rad_ext  = {11'b0, i_cfg.stick_radius};
    assign w_dead_ext = {11'b0, i_cfg.dead_radius};

    always_ff @(posedge i_clk) begin
        r_rad_sq  <= w_rad_ext * w_rad_ext;
        r_dead_sq <= w_dead_ext * w_dead_ext;
    end

    assign w_dsq  = DQ'(r_pl[ST_CMP-1].xx) + DQ'(r_pl[ST_CMP-1].yy);
    assign o_kill = r_pl[ST_CMP-1].began && !(w_dsq < DQ'(r_rad_sq));

    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++) begin : g_stage
            t_item n_st;

            if (k == 0) begin : g_in
                always_comb begin
                    n_st       = '0;
                    n_st.began = (i_operation == OP_BEGAN);
                    if (i_operation == OP_BEGAN || i_operation == OP_MOVED) begin
                        n_st.x = i_offset_x;
                        n_st.y = i_offset_y;
                    end
                end
            end else if (k == 1) begin : g_sq
                always_comb begin
                    logic signed [2*CB-1:0] xe;
                    logic signed [2*CB-1:0] ye;
                    n_st = r_pl[k-1];
                    xe   = (2*CB)'(r_pl[k-1].x);
                    ye   = (2*CB)'(r_pl[k-1].y);
                    n_st.xx = xe * xe;
                    n_st.yy = ye * ye;
                end
            end else if (k == ST_CMP) begin : g_cmp
                always_comb begin
                    logic signed [WV-1:0] xs;
                    logic signed [WV-1:0] ys;
                    logic [CB-1:0]        mx;
                    logic [CB-1:0]        my;
                    logic [NW-1:0]        nx;
                    logic [NW-1:0]        ny;
                    n_st       = r_pl[k-1];
                    n_st.dead  = w_dsq <= DQ'(r_dead_sq);
                    n_st.pad   = i_cfg.pad_mode;
                    n_st.clamp = (w_dsq > DQ'(r_rad_sq)) || i_cfg.pad_mode;
                    xs = WV'(r_pl[k-1].x) <<< 20;
                    ys = WV'(r_pl[k-1].y) <<< 20;
                    n_st.vx_c = xs;
                    n_st.vy_c = ys;
                    n_st.z    = 16'd0;
                    if (xs < 0) begin
                        if (ys >= 0) begin
                            n_st.vx_c = ys;
                            n_st.vy_c = -xs;
                            n_st.z    = 16'h4000;
                        end else begin
                            n_st.vx_c = -ys;
                            n_st.vy_c = xs;
                            n_st.z    = 16'hC000;
                        end
                    end
                    mx = r_pl[k-1].x[CB-1] ? CB'(-r_pl[k-1].x) : CB'(r_pl[k-1].x);
                    my = r_pl[k-1].y[CB-1] ? CB'(-r_pl[k-1].y) : CB'(r_pl[k-1].y);
                    nx = NW'({mx, 14'b0}) + NW'(i_cfg.stick_radius >> 1);
                    ny = NW'({my, 14'b0}) + NW'(i_cfg.stick_radius >> 1);
                    n_st.wx = {11'(nx >> 15), nx[14:0]};
                    n_st.wy = {11'(ny >> 15), ny[14:0]};
                end
            end else if (k >= ST_VEC0 && k < ST_VEC0 + CORDIC_N) begin : g_vec
                localparam int I = k - ST_VEC0;
                always_comb begin
                    logic signed [WV-1:0] ax;
                    logic signed [WV-1:0] ay;
                    n_st = r_pl[k-1];
                    ax   = r_pl[k-1].vx_c >>> I;
                    ay   = r_pl[k-1].vy_c >>> I;
                    if (r_pl[k-1].vy_c > 0) begin
                        n_st.vx_c = r_pl[k-1].vx_c + ay;
                        n_st.vy_c = r_pl[k-1].vy_c - ax;
                        n_st.z    = r_pl[k-1].z + ATAN_UNITS[I];
                    end else begin
                        n_st.vx_c = r_pl[k-1].vx_c - ay;
                        n_st.vy_c = r_pl[k-1].vy_c + ax;
                        n_st.z    = r_pl[k-1].z - ATAN_UNITS[I];
                    end
                    if (I < VDIV_STEPS) begin
                        n_st.wx = vdiv_step(r_pl[k-1].wx, i_cfg.stick_radius);
                        n_st.wy = vdiv_step(r_pl[k-1].wy, i_cfg.stick_radius);
                    end
                    if (I == CORDIC_N - 1) begin
                        n_st.ang = n_st.z;
                    end
                end
            end else if (k == ST_SNAP) begin : g_snap
                always_comb begin
                    logic [4:0]  nsec;
                    logic [21:0] prod;
                    logic [21:0] num;
                    n_st = r_pl[k-1];
                    nsec = (i_cfg.sector_count == 5'd0) ? 5'd1 : i_cfg.sector_count;
                    prod = {6'b0, r_pl[k-1].ang} * {17'b0, nsec} + 22'd32768;
                    num  = {prod[21:16], 16'b0} + 22'(nsec >> 1);
                    n_st.n  = nsec;
                    n_st.sw = SD_W'(num);
                end
            end else if (k >= ST_SDIV0 && k < ST_SDIV0 + SDIV_STG) begin : g_sdiv
                always_comb begin
                    logic [SD_W-1:0] w;
                    n_st = r_pl[k-1];
                    w    = r_pl[k-1].sw;
                    for (int j = 0; j < SDIV_PER; j++) begin
                        w = sdiv_step(w, r_pl[k-1].n);
                    end
                    n_st.sw = w;
                end
            end else if (k == ST_ROTI) begin : g_roti
                always_comb begin
                    logic [15:0] a;
                    n_st = r_pl[k-1];
                    a    = r_pl[k-1].pad ? r_pl[k-1].sw[15:0] : r_pl[k-1].ang;
                    n_st.ang  = a;
                    n_st.rz   = $signed({2'b0, a});
                    n_st.flip = 1'b0;
                    if (a >= 16'd16384 && a < 16'd49152) begin
                        n_st.rz   = $signed({2'b0, a}) - 18'sd32768;
                        n_st.flip = 1'b1;
                    end else if (a >= 16'd49152) begin
                        n_st.rz = $signed({2'b0, a}) - 18'sd65536;
                    end
                    n_st.rx = ROT_GAIN;
                    n_st.ry = '0;
                end
            end else if (k >= ST_ROT0 && k < ST_ROT0 + CORDIC_N) begin : g_rot
                localparam int I = k - ST_ROT0;
                always_comb begin
                    logic signed [RX_W-1:0] ax;
                    logic signed [RX_W-1:0] ay;
                    logic signed [RZ_W-1:0] at;
                    n_st = r_pl[k-1];
                    ax   = r_pl[k-1].rx >>> I;
                    ay   = r_pl[k-1].ry >>> I;
                    at   = $signed({2'b0, ATAN_UNITS[I]});
                    if (r_pl[k-1].rz >= 0) begin
                        n_st.rx = r_pl[k-1].rx - ay;
                        n_st.ry = r_pl[k-1].ry + ax;
                        n_st.rz = r_pl[k-1].rz - at;
                    end else begin
                        n_st.rx = r_pl[k-1].rx + ay;
                        n_st.ry = r_pl[k-1].ry - ax;
                        n_st.rz = r_pl[k-1].rz + at;
                    end
                end
            end else if (k == ST_FLIP) begin : g_flip
                always_comb begin
                    n_st = r_pl[k-1];
                    if (r_pl[k-1].flip) begin
                        n_st.rx = -r_pl[k-1].rx;
                        n_st.ry = -r_pl[k-1].ry;
                    end
                    n_st.qx = to_q14(n_st.rx);
                    n_st.qy = to_q14(n_st.ry);
                end
            end else if (k == ST_MUL) begin : g_mul
                always_comb begin
                    logic signed [45:0] ce;
                    logic signed [45:0] se;
                    logic signed [45:0] re;
                    logic signed [45:0] pc;
                    logic signed [45:0] ps;
                    n_st = r_pl[k-1];
                    ce   = 46'(r_pl[k-1].rx);
                    se   = 46'(r_pl[k-1].ry);
                    re   = $signed(46'({1'b0, i_cfg.stick_radius}));
                    pc   = (ce * re + 46'sd536870912) >>> 30;
                    ps   = (se * re + 46'sd536870912) >>> 30;
                    n_st.tcx = TW'(pc);
                    n_st.tcy = TW'(ps);
                end
            end else begin : g_out
                always_comb begin
                    logic signed [TW-1:0] tx;
                    logic signed [TW-1:0] ty;
                    logic [TW-1:0]        mx;
                    logic [TW-1:0]        my;
                    logic [15:0]          a;
                    n_st = r_pl[k-1];
                    a    = r_pl[k-1].ang;
                    if (r_pl[k-1].dead) begin
                        n_st.qx = '0;
                        n_st.qy = '0;
                        tx      = TW'(r_pl[k-1].x);
                        ty      = TW'(r_pl[k-1].y);
                        a       = 16'd0;
                    end else if (r_pl[k-1].clamp) begin
                        tx = r_pl[k-1].tcx;
                        ty = r_pl[k-1].tcy;
                    end else begin
                        n_st.qx = div_vel(r_pl[k-1].wx, r_pl[k-1].x[CB-1]);
                        n_st.qy = div_vel(r_pl[k-1].wy, r_pl[k-1].y[CB-1]);
                        tx      = TW'(r_pl[k-1].x);
                        ty      = TW'(r_pl[k-1].y);
                    end
                    mx = tx[TW-1] ? TW'(-tx) : TW'(tx);
                    my = ty[TW-1] ? TW'(-ty) : TW'(ty);
                    n_st.ang = a;
                    n_st.tcx = tx;
                    n_st.tcy = ty;
                    if (!i_cfg.button_mode || r_pl[k-1].dead) begin
                        n_st.dir = DIR_NONE;
                    end else if (mx < TW'(NEAR_ZERO_LIMIT) && my < TW'(NEAR_ZERO_LIMIT)) begin
                        n_st.dir = DIR_NONE;
                    end else if (a < 16'd8192 || a >= 16'd57344) begin
                        n_st.dir = DIR_RIGHT;
                    end else if (a >= 16'd24576 && a < 16'd40960) begin
                        n_st.dir = DIR_LEFT;
                    end else if (a < 16'd24576) begin
                        n_st.dir = DIR_UP;
                    end else begin
                        n_st.dir = DIR_DOWN;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pl[k] <= n_st;
                end
            end
        end
    endgenerate

    assign o_velocity_x   = r_pl[ST_OUT].qx;
    assign o_velocity_y   = r_pl[ST_OUT].qy;
    assign o_angle        = r_pl[ST_OUT].ang;
    assign o_thumb_x      = CB'(r_pl[ST_OUT].tcx);
    assign o_thumb_y      = CB'(r_pl[ST_OUT].tcy);
    assign o_direction    = r_pl[ST_OUT].dir;
    assign o_in_dead_zone = r_pl[ST_OUT].dead;

endmodule

`default_nettype wire

// ===== hdl/joystick_direction_mapper.sv =====
// ----------------------------------------------------------------------------
// joystick_direction_mapper
// maps stick events to velocity, angle, thumb position and direction code
// ----------------------------------------------------------------------------
// usage
// input stream: tuser carries the event kind, tdata the signed offset pair.
// output stream: tdata carries velocity, angle, thumb and direction, tuser the
// dead-zone flag. a began event on or outside the stick circle yields no output.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// no request is in flight.
// throughput: one request per cycle while the skid register is empty, set
// by a 48-stage pipeline in which each cordic iteration and each group of
// sector divider steps owns a stage.
// reset clears all valid bits and loads the register defaults.
// when the receiver stalls, the last result moves to a skid register and
// the pipeline stops once that register is full; o_s_tready then drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_direction_mapper #(
    parameter int COORD_BITS      = 12,
    parameter int NEAR_ZERO_LIMIT = 5
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // config write port
    input  wire logic                                      i_cfg_we,
    input  wire logic [2:0]                                i_cfg_idx,
    input  wire logic [10:0]                               i_cfg_data,
    // request stream
    input  wire logic                                      i_s_tvalid,
    output logic                                           o_s_tready,
    // offset_x, offset_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]         i_s_tdata,
    // operation
    input  wire logic [1:0]                                i_s_tuser,
    // result stream
    output logic                                           o_m_tvalid,
    input  wire logic                                      i_m_tready,
    // velocity_x, velocity_y, angle, thumb_x, thumb_y, direction
    output logic [((51+2*COORD_BITS+7)/8)*8-1:0]           o_m_tdata,
    // in_dead_zone
    output logic                                           o_m_tuser
);
    import jdm_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int ODW = ((51 + 2 * CB + 7) / 8) * 8;

    t_cfg                    r_cfg;
    logic [NUM_STAGES-1:0]   r_vld;
    logic                    r_skid_vld;
    logic [ODW-1:0]          r_skid_data;
    logic                    r_skid_user;
    logic                    w_en;
    logic                    w_kill;
    logic signed [15:0]      w_vx;
    logic signed [15:0]      w_vy;
    logic [15:0]             w_ang;
    logic signed [CB-1:0]    w_tx;
    logic signed [CB-1:0]    w_ty;
    logic [2:0]              w_dir;
    logic                    w_dead;
    logic [ODW-1:0]          w_pipe_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_radius <= 11'd100;
            r_cfg.dead_radius  <= 11'd0;
            r_cfg.pad_mode     <= 1'b0;
            r_cfg.sector_count <= 5'd4;
            r_cfg.button_mode  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STICK_RADIUS: r_cfg.stick_radius <= i_cfg_data;
                CFG_DEAD_RADIUS:  r_cfg.dead_radius  <= i_cfg_data;
                CFG_PAD_MODE:     r_cfg.pad_mode     <= i_cfg_data[0];
                CFG_SECTOR_COUNT: r_cfg.sector_count <= i_cfg_data[4:0];
                CFG_BUTTON_MODE:  r_cfg.button_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_en       = !r_skid_vld;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (k == 0) begin
                    r_vld[k] <= i_s_tvalid;
                end else if (k == ST_CMP) begin
                    r_vld[k] <= r_vld[k-1] && !w_kill;
                end else begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    jdm_datapath #(
        .COORD_BITS      (COORD_BITS),
        .NEAR_ZERO_LIMIT (NEAR_ZERO_LIMIT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_cfg          (r_cfg),
        .i_operation    (i_s_tuser),
        .i_offset_x     (i_s_tdata[CB-1:0]),
        .i_offset_y     (i_s_tdata[2*CB-1:CB]),
        .o_kill         (w_kill),
        .o_velocity_x   (w_vx),
        .o_velocity_y   (w_vy),
        .o_angle        (w_ang),
        .o_thumb_x      (w_tx),
        .o_thumb_y      (w_ty),
        .o_direction    (w_dir),
        .o_in_dead_zone (w_dead)
    );

    assign w_pipe_data = ODW'({w_dir, w_ty, w_tx, w_ang, w_vy, w_vx});

    // skid register parts the output from the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[ST_OUT] && !i_m_tready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_data <= w_pipe_data;
            r_skid_user <= w_dead;
        end
    end

    assign o_m_tvalid = r_skid_vld || r_vld[ST_OUT];
    assign o_m_tdata  = r_skid_vld ? r_skid_data : w_pipe_data;
    assign o_m_tuser  = r_skid_vld ? r_skid_user : w_dead;

endmodule

`default_nettype wire

// ===== hdl/jdm_checker.sv =====
// ----------------------------------------------------------------------------
// jdm_checker
// port-level checks on the result stream of the stick mapper
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jdm_checker #(
    parameter int COORD_BITS = 12
) (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_m_tready,
    input wire logic                                  o_m_tvalid,
    input wire logic [((51+2*COORD_BITS+7)/8)*8-1:0]  o_m_tdata,
    input wire logic                                  o_m_tuser
);
    localparam int DIR_LO = 48 + 2 * COORD_BITS;

    `JDM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid)

    `JDM_ASSERT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    `JDM_ASSERT(a_dead_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> o_m_tdata[47:0] == 48'd0 && o_m_tdata[DIR_LO+2:DIR_LO] == 3'd0)

    `JDM_ASSERT(a_vel_range, i_clk, i_rst_n, o_m_tvalid |-> $signed(o_m_tdata[15:0]) <= 16'sd16384 && $signed(o_m_tdata[15:0]) >= -16'sd16384 && $signed(o_m_tdata[31:16]) <= 16'sd16384 && $signed(o_m_tdata[31:16]) >= -16'sd16384)

endmodule

bind joystick_direction_mapper jdm_checker #(
    .COORD_BITS (COORD_BITS)
) u_jdm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
